FILE: rtl/nab_pkg.sv
// nab_pkg: shared constants, pixel type and the eighth-sum helper for the
// neighbour average blur. No dependencies; used by the interfaces and the top.
package nab_pkg;

	localparam int CH_W = 8;
	localparam int PIX_W = 3 * CH_W;

	// configuration register widths, reset values and index codes
	localparam int FW_W = 11;
	localparam int FH_W = 13;
	localparam int FW_RESET = 1024;
	localparam int FH_RESET = 768;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic REG_FRAME_WIDTH = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// default frame limits
	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;

	// result queue
	localparam int RQ_DEPTH = 8;
	localparam int RQ_PTR_W = 3;
	localparam int RQ_CNT_W = 4;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pixel_t;

	typedef logic [CH_W-1:0] chan8_t [8];

	// sum of eight components, each divided by 8 first; max 8*31 fits in 8 bits
	function automatic logic [CH_W-1:0] eighth_sum(input chan8_t v);
		logic [CH_W-1:0] s;
		s = '0;
		for (int k = 0; k < 8; k++) begin
			s = s + {3'b000, v[k][CH_W-1:3]};
		end
		return s;
	endfunction

endpackage

FILE: rtl/nab_ifs.sv
// nab_ifs: valid/ready stream interfaces for input pixels and blur results.
// Depends on nab_pkg for the component width.
interface nab_pixel_if;
	logic                     valid;
	logic                     ready;
	logic [nab_pkg::CH_W-1:0] in_red;
	logic [nab_pkg::CH_W-1:0] in_green;
	logic [nab_pkg::CH_W-1:0] in_blue;

	modport source (output valid, in_red, in_green, in_blue, input ready);
	modport sink (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface nab_result_if #(
	parameter int ROW_W = 12,
	parameter int COL_W = 10
);
	logic                     valid;
	logic                     ready;
	logic [nab_pkg::CH_W-1:0] out_red;
	logic [nab_pkg::CH_W-1:0] out_green;
	logic [nab_pkg::CH_W-1:0] out_blue;
	logic [ROW_W-1:0]         out_row;
	logic [COL_W-1:0]         out_column;
	logic                     frame_done;

	modport source (output valid, out_red, out_green, out_blue, out_row, out_column,
		frame_done, input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_row, out_column,
		frame_done, output ready);
endinterface

FILE: rtl/neighbour_average_blur.sv
// neighbour_average_blur: streaming 3x3 neighbour-average blur with two line stores.
// Depends on nab_pkg and the stream interfaces in nab_ifs.sv.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+------------------------------------------
//  pix     | in  | valid/ready       | in_red, in_green, in_blue (raster order)
//  res     | out | valid/ready       | out_red/green/blue, out_row, out_column,
//          |     |                   | frame_done
//  apb     | cfg | psel/penable/pready | frame_width @0x0, frame_height @0x4
//
// One pixel per clock while pix.ready is high. A transaction on pix is registered into
// stage s1 with the line store reads for its column; s1 computes the eighth-sums and
// pushes 0, 1 or 2 results into an 8-entry result queue in the same cycle.
// pix.ready drops only when the queue may not take the results of the pixels
// already in flight (the last row of a frame yields two results a pixel, so it runs
// at the output rate). Reset (arst_n, asynchronous) clears positions, window and queue;
// line stores are not cleared and hold nothing meaningful until the first rows pass.
module neighbour_average_blur #(
	parameter int MAX_WIDTH  = nab_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = nab_pkg::DEF_MAX_HEIGHT,
	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [nab_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [nab_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [nab_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                               pready,
	nab_pixel_if.sink                          pix,
	nab_result_if.source                       res
);

	localparam int RES_W = nab_pkg::PIX_W + ROW_W + COL_W + 1;
	localparam int LAST_COL_RST =
		((nab_pkg::FW_RESET < MAX_WIDTH) ? nab_pkg::FW_RESET : MAX_WIDTH) - 1;
	localparam int LAST_ROW_RST =
		((nab_pkg::FH_RESET < MAX_HEIGHT) ? nab_pkg::FH_RESET : MAX_HEIGHT) - 1;

	// ---------------------------------------------------------------- config
	logic [nab_pkg::FW_W-1:0] fw_q;
	logic [nab_pkg::FH_W-1:0] fh_q;
	logic [COL_W-1:0]         last_col_q;
	logic [ROW_W-1:0]         last_row_q;
	logic                     cfg_wr;
	logic                     cfg_sel;
	logic [nab_pkg::FW_W-1:0] fw_new;
	logic [nab_pkg::FH_W-1:0] fh_new;

	assign pready  = 1'b1;
	assign cfg_sel = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign fw_new  = pwdata[nab_pkg::FW_W-1:0];
	assign fh_new  = pwdata[nab_pkg::FH_W-1:0];

	always_comb begin
		case (cfg_sel)
			nab_pkg::REG_FRAME_WIDTH:  prdata = 32'(fw_q);
			nab_pkg::REG_FRAME_HEIGHT: prdata = 32'(fh_q);
			default:                   prdata = '0;
		endcase
	end

	// last column / row indices are kept already clamped to the legal range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q       <= nab_pkg::FW_W'(nab_pkg::FW_RESET);
			fh_q       <= nab_pkg::FH_W'(nab_pkg::FH_RESET);
			last_col_q <= COL_W'(LAST_COL_RST);
			last_row_q <= ROW_W'(LAST_ROW_RST);
		end else if (cfg_wr) begin
			case (cfg_sel)
				nab_pkg::REG_FRAME_WIDTH: begin
					fw_q <= fw_new;
					if (fw_new == '0)
						last_col_q <= '0;
					else if (32'(fw_new) > 32'(MAX_WIDTH))
						last_col_q <= COL_W'(MAX_WIDTH - 1);
					else
						last_col_q <= COL_W'(fw_new - 1'b1);
				end
				nab_pkg::REG_FRAME_HEIGHT: begin
					fh_q <= fh_new;
					if (fh_new == '0)
						last_row_q <= '0;
					else if (32'(fh_new) > 32'(MAX_HEIGHT))
						last_row_q <= ROW_W'(MAX_HEIGHT - 1);
					else
						last_row_q <= ROW_W'(fh_new - 1'b1);
				end
				default: ;
			endcase
		end
	end

	// -------------------------------------------------------- position / accept
	localparam int RQ_CNT_W_L = nab_pkg::RQ_CNT_W;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_e;
	logic [ROW_W-1:0] row_e;
	logic             accept;
	logic             s1_valid_q;
	logic [RQ_CNT_W_L-1:0] rq_cnt_q;

	// a position beyond the frame (only after shrinking) restarts at zero
	assign col_e = (col_q > last_col_q) ? '0 : col_q;
	assign row_e = (row_q > last_row_q) ? '0 : row_q;

	// room for two results of the pixel in s1 and two of the new one
	assign pix.ready = s1_valid_q ? (rq_cnt_q <= RQ_CNT_W_L'(nab_pkg::RQ_DEPTH - 4))
	                              : (rq_cnt_q <= RQ_CNT_W_L'(nab_pkg::RQ_DEPTH - 2));
	assign accept = pix.valid && pix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_e == last_col_q) begin
				col_q <= '0;
				row_q <= (row_e == last_row_q) ? '0 : row_e + 1'b1;
			end else begin
				col_q <= col_e + 1'b1;
				row_q <= row_e;
			end
		end
	end

	// ------------------------------------------------------------- stage s1
	nab_pkg::pixel_t  px_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             inner_s1;
	logic             border_s1;
	logic             done_s1;
	logic             fwd_s1;
	nab_pkg::pixel_t  fwd_top_s1;
	nab_pkg::pixel_t  fwd_mid_s1;
	nab_pkg::pixel_t  top_rd_s1;
	nab_pkg::pixel_t  mid_rd_s1;
	nab_pkg::pixel_t  top_e;
	nab_pkg::pixel_t  mid_e;
	nab_pkg::pixel_t  px_in;

	assign px_in = '{red: pix.in_red, green: pix.in_green, blue: pix.in_blue};

	// line stores: read at accept, written back from s1
	nab_pkg::pixel_t older_mem [MAX_WIDTH];
	nab_pkg::pixel_t newer_mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (s1_valid_q)
			older_mem[col_s1] <= mid_e;
		if (accept)
			top_rd_s1 <= older_mem[col_e];
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q)
			newer_mem[col_s1] <= px_s1;
		if (accept)
			mid_rd_s1 <= newer_mem[col_e];
	end

	// back-to-back pixels on the same column (one-pixel-wide frame): the store
	// write of s1 lands on the same edge as the read, so take the fresh values
	assign top_e = fwd_s1 ? fwd_top_s1 : top_rd_s1;
	assign mid_e = fwd_s1 ? fwd_mid_s1 : mid_rd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else
			s1_valid_q <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1      <= px_in;
			col_s1     <= col_e;
			row_s1     <= row_e;
			inner_s1   <= (row_e >= ROW_W'(2)) && (col_e >= COL_W'(2));
			border_s1  <= (row_e == '0) || (col_e == '0) ||
			              (row_e == last_row_q) || (col_e == last_col_q);
			done_s1    <= (row_e == last_row_q) && (col_e == last_col_q);
			fwd_s1     <= s1_valid_q && (col_s1 == col_e);
			fwd_top_s1 <= mid_e;
			fwd_mid_s1 <= px_s1;
		end
	end

	// window of the two previous columns: [0..2] older column, [3..5] newer
	nab_pkg::pixel_t win_q [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				win_q[i] <= '0;
		end else if (s1_valid_q) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_e;
			win_q[4] <= mid_e;
			win_q[5] <= px_s1;
		end
	end

	// eight neighbours; win_q[4] is the centre and is left out
	nab_pkg::chan8_t nb_r, nb_g, nb_b;
	nab_pkg::pixel_t avg;

	always_comb begin
		nb_r = '{win_q[0].red, win_q[1].red, win_q[2].red, win_q[3].red,
		         win_q[5].red, top_e.red, mid_e.red, px_s1.red};
		nb_g = '{win_q[0].green, win_q[1].green, win_q[2].green, win_q[3].green,
		         win_q[5].green, top_e.green, mid_e.green, px_s1.green};
		nb_b = '{win_q[0].blue, win_q[1].blue, win_q[2].blue, win_q[3].blue,
		         win_q[5].blue, top_e.blue, mid_e.blue, px_s1.blue};
		avg.red   = nab_pkg::eighth_sum(nb_r);
		avg.green = nab_pkg::eighth_sum(nb_g);
		avg.blue  = nab_pkg::eighth_sum(nb_b);
	end

	// ---------------------------------------------------------- result queue
	logic [RES_W-1:0] inner_res;
	logic [RES_W-1:0] border_res;
	logic [RES_W-1:0] first_res;
	logic             push1;
	logic             push2;
	logic             pop;
	logic [RES_W-1:0] rq_q [nab_pkg::RQ_DEPTH];
	logic [nab_pkg::RQ_PTR_W-1:0] wr_ptr_q;
	logic [nab_pkg::RQ_PTR_W-1:0] rd_ptr_q;
	logic [RES_W-1:0] head;

	assign inner_res  = {avg, row_s1 - 1'b1, col_s1 - 1'b1, 1'b0};
	assign border_res = {px_s1, row_s1, col_s1, done_s1};
	assign first_res  = inner_s1 ? inner_res : border_res;
	assign push1      = s1_valid_q && (inner_s1 || border_s1);
	assign push2      = s1_valid_q && inner_s1 && border_s1;
	assign pop        = res.valid && res.ready;

	always_ff @(posedge clk) begin
		if (push1)
			rq_q[wr_ptr_q] <= first_res;
		if (push2)
			rq_q[wr_ptr_q + 1'b1] <= border_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			rq_cnt_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + {2'b00, push1} + {2'b00, push2};
			rd_ptr_q <= rd_ptr_q + {2'b00, pop};
			rq_cnt_q <= rq_cnt_q + {3'b000, push1} + {3'b000, push2} - {3'b000, pop};
		end
	end

	assign head           = rq_q[rd_ptr_q];
	assign res.valid      = (rq_cnt_q != '0);
	assign res.out_red    = head[RES_W-1 -: nab_pkg::CH_W];
	assign res.out_green  = head[RES_W-1-nab_pkg::CH_W -: nab_pkg::CH_W];
	assign res.out_blue   = head[RES_W-1-2*nab_pkg::CH_W -: nab_pkg::CH_W];
	assign res.out_row    = head[COL_W+ROW_W -: ROW_W];
	assign res.out_column = head[COL_W -: COL_W];
	assign res.frame_done = head[0];

	// ------------------------------------------------------------ assertions
	a_rq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rq_cnt_q <= RQ_CNT_W_L'(nab_pkg::RQ_DEPTH))
		else $error("result queue overfilled");

	a_rq_room: assert property (@(posedge clk) disable iff (!arst_n)
		push2 |-> (rq_cnt_q <= RQ_CNT_W_L'(nab_pkg::RQ_DEPTH - 2)))
		else $error("two results pushed without room");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= last_col_q)
		else $error("column position beyond frame");

	a_fwd_only_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && fwd_s1) |-> $past(s1_valid_q))
		else $error("store forwarding without a preceding transaction");

endmodule
